### hw/rtl/psi_pkg.sv
// shared types and register codes for the segment / plane intersection block
`timescale 1ns / 1ps
`default_nettype none
package psi_pkg;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X     = 2'd0,
    REG_NORMAL_Y     = 2'd1,
    REG_NORMAL_Z     = 2'd2,
    REG_PLANE_OFFSET = 2'd3
  } psi_reg_t;

  // pipeline control handed to the divider
  typedef struct packed {
    logic en;
    logic valid;
  } psi_ctl_t;

endpackage
`default_nettype wire

### hw/rtl/psi_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module psi_div #(
  parameter int RW = 68,
  parameter int FB = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  psi_pkg::psi_ctl_t   ctl,
  input  wire  [RW-1:0]       r_in,
  input  wire  [RW-1:0]       den_in,
  input  wire                 t0_in,
  output logic                valid_out,
  output logic [FB:0]         t_out
);
  import psi_pkg::*;

  logic [RW-1:0] r_r   [FB];
  logic [RW-1:0] den_r [FB];
  logic [FB:0]   t_r   [FB];
  logic          v_r   [FB];

  logic [RW-1:0] r_nxt [FB];
  logic [FB:0]   t_nxt [FB];

  genvar k;
  generate
    for (k = 0; k < FB; k++) begin : g_stage
      logic [RW-1:0] r_cur;
      logic [RW-1:0] d_cur;
      logic [FB:0]   t_cur;
      logic          v_cur;
      logic [RW-1:0] r2;
      logic          ge;

      if (k == 0) begin : g_first
        assign r_cur = r_in;
        assign d_cur = den_in;
        assign t_cur = {{FB{1'b0}}, t0_in};
        assign v_cur = ctl.valid;
      end else begin : g_rest
        assign r_cur = r_r[k-1];
        assign d_cur = den_r[k-1];
        assign t_cur = t_r[k-1];
        assign v_cur = v_r[k-1];
      end

      always_comb begin
        r2       = {r_cur[RW-2:0], 1'b0};
        ge       = (r2 >= d_cur);
        r_nxt[k] = ge ? (r2 - d_cur) : r2;
        t_nxt[k] = {t_cur[FB-1:0], ge};
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (ctl.en) begin
          v_r[k] <= v_cur;
        end
        if (ctl.en) begin
          r_r[k]   <= r_nxt[k];
          den_r[k] <= d_cur;
          t_r[k]   <= t_nxt[k];
        end
      end
    end
  endgenerate

  assign valid_out = v_r[FB-1];
  assign t_out     = t_r[FB-1];

`ifndef SYNTH
  // quotient never exceeds one
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_out |-> (!t_out[FB] || (t_out[FB-1:0] == '0)))
    else $error("quotient above one");
  // partial remainder stays below the divisor
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[FB-1] |-> (r_r[FB-1] < den_r[FB-1]) || (den_r[FB-1] == '0))
    else $error("remainder not reduced");
  // a stalled divider holds its valid bits
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.en |=> $stable(valid_out))
    else $error("divider moved during stall");
`endif

endmodule
`default_nettype wire

### hw/rtl/plane_segment_intersection.sv
// top level: segment against configured plane, fully pipelined
`timescale 1ns / 1ps
`default_nettype none
// Tests one segment per transaction against the plane A*x+B*y+C*z+D=0 held in
// four configuration registers (index 0..3: normal_x, normal_y, normal_z,
// plane_offset). A new segment is accepted every cycle while the pipeline
// advances. The pipeline runs through the six-multiplier front end, the
// distance adder, the side test, one divider stage per quotient bit, the offset
// multiplier and the output register. The whole pipeline advances when the
// output register is empty or being taken.
// out_tuser carries hit; point fields read zero when hit is low.
module plane_segment_intersection #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [psi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [COORD_BITS-1:0]             cfg_data,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, zero pad
  input  wire  [((6*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // point_x, point_y, point_z, zero pad
  output logic [((3*COORD_BITS+7)/8)*8-1:0] out_tdata,
  // hit
  output logic                              out_tuser
);
  import psi_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int OW = ((3*COORD_BITS+7)/8)*8;
  localparam int DW = 2*C + 2;
  localparam int RW = DW + 2;
  localparam int MW = C + 1 + F + 1;

  logic signed [C-1:0] nrm_r [3];
  logic signed [C-1:0] ofs_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_r[0] <= '0;
      nrm_r[1] <= '0;
      nrm_r[2] <= '0;
      ofs_r    <= '0;
    end else if (cfg_valid) begin
      unique case (psi_reg_t'(cfg_index))
        REG_NORMAL_X:     nrm_r[0] <= cfg_data;
        REG_NORMAL_Y:     nrm_r[1] <= cfg_data;
        REG_NORMAL_Z:     nrm_r[2] <= cfg_data;
        REG_PLANE_OFFSET: ofs_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // stage 1: products and deltas
  logic signed [C-1:0]   s_in [3];
  logic signed [C-1:0]   e_in [3];
  logic                  v1_r;
  logic signed [2*C-1:0] p1_r [3];
  logic signed [2*C-1:0] p2_r [3];
  logic signed [C-1:0]   s1_r [3];
  logic signed [C:0]     dl1_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_in[i] = in_tdata[i*C +: C];
      e_in[i] = in_tdata[(i+3)*C +: C];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[i]  <= nrm_r[i] * s_in[i];
        p2_r[i]  <= nrm_r[i] * e_in[i];
        s1_r[i]  <= s_in[i];
        dl1_r[i] <= {e_in[i][C-1], e_in[i]} - {s_in[i][C-1], s_in[i]};
      end
    end
  end

  // stage 2: signed distances
  logic signed [DW-1:0] ofs_w;
  logic                 v2_r;
  logic signed [DW-1:0] d1_r;
  logic signed [DW-1:0] d2_r;
  logic signed [C-1:0]  s2_r [3];
  logic signed [C:0]    dl2_r [3];

  assign ofs_w = DW'(ofs_r) <<< F;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      d1_r <= ofs_w + DW'(p1_r[0]) + DW'(p1_r[1]) + DW'(p1_r[2]);
      d2_r <= ofs_w + DW'(p2_r[0]) + DW'(p2_r[1]) + DW'(p2_r[2]);
      s2_r  <= s1_r;
      dl2_r <= dl1_r;
    end
  end

  // stage 3: side test and divider operands
  logic          neg1, neg2;
  logic [DW-1:0] m1, m2;
  logic          v3_r;
  logic          hit3_r;
  logic          t03_r;
  logic [RW-1:0] r3_r;
  logic [RW-1:0] den3_r;
  logic signed [C-1:0] s3_r [3];
  logic signed [C:0]   dl3_r [3];

  always_comb begin
    neg1 = d1_r[DW-1];
    neg2 = d2_r[DW-1];
    m1   = neg1 ? DW'(-d1_r) : DW'(d1_r);
    m2   = neg2 ? DW'(-d2_r) : DW'(d2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      hit3_r <= neg1 ^ neg2;
      // end point on the plane: quotient is exactly one
      t03_r  <= (m2 == '0) && (m1 != '0);
      r3_r   <= (m2 == '0) ? '0 : RW'(m1);
      den3_r <= RW'(m1) + RW'(m2);
      s3_r   <= s2_r;
      dl3_r  <= dl2_r;
    end
  end

  // divider, with payload delay line alongside
  psi_ctl_t      div_ctl;
  logic          div_valid;
  logic [F:0]    div_t;

  assign div_ctl.en    = adv;
  assign div_ctl.valid = v3_r;

  psi_div #(.RW(RW), .FB(F)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .r_in      (r3_r),
    .den_in    (den3_r),
    .t0_in     (t03_r),
    .valid_out (div_valid),
    .t_out     (div_t)
  );

  logic signed [C-1:0] sl_r  [F][3];
  logic signed [C:0]   dll_r [F][3];
  logic                hl_r  [F];

  always_ff @(posedge clk) begin
    if (adv) begin
      sl_r[0]  <= s3_r;
      dll_r[0] <= dl3_r;
      hl_r[0]  <= hit3_r;
      for (int k = 1; k < F; k++) begin
        sl_r[k]  <= sl_r[k-1];
        dll_r[k] <= dll_r[k-1];
        hl_r[k]  <= hl_r[k-1];
      end
    end
  end

  // stage 4: segment delta magnitude times quotient
  logic [C:0]          dmag [3];
  logic                v4_r;
  logic                hit4_r;
  logic [MW-1:0]       pr4_r  [3];
  logic                neg4_r [3];
  logic signed [C-1:0] s4_r   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i] = dll_r[F-1][i][C] ? (C+1)'(-dll_r[F-1][i]) : (C+1)'(dll_r[F-1][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= div_valid;
    end
    if (adv) begin
      hit4_r <= hl_r[F-1];
      for (int i = 0; i < 3; i++) begin
        pr4_r[i]  <= MW'(dmag[i]) * MW'(div_t);
        neg4_r[i] <= dll_r[F-1][i][C];
        s4_r[i]   <= sl_r[F-1][i];
      end
    end
  end

  // output register
  logic [C:0]    q4   [3];
  logic [C-1:0]  pt4  [3];
  logic [OW-1:0] pack4;

  always_comb begin
    pack4 = '0;
    for (int i = 0; i < 3; i++) begin
      q4[i]  = pr4_r[i][F +: C+1];
      pt4[i] = s4_r[i] + (neg4_r[i] ? C'(-q4[i]) : C'(q4[i]));
      if (hit4_r) begin
        pack4[i*C +: C] = pt4[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (adv) begin
      out_tvalid <= v4_r;
    end
    if (adv) begin
      out_tdata <= pack4;
      out_tuser <= hit4_r;
    end
  end

`ifndef SYNTH
  // a miss always carries a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("nonzero point on miss");
  // stalled pipeline keeps its occupancy
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v1_r) && $stable(v2_r) && $stable(v3_r) && $stable(v4_r))
    else $error("pipeline moved during stall");
  // an accepted segment reaches stage one
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("transaction lost at entry");
`endif

endmodule
`default_nettype wire

### tb/plane_segment_intersection_checker.sv
// checker: predicts segment / plane crossings and compares the result stream
`timescale 1ns / 1ps
module plane_segment_intersection_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [191:0] in_tdata,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [95:0] out_tdata,
  input  wire         out_tuser,
  output int          fail_count,
  output int          pending
);
  import psi_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } crossing_t;

  logic signed [31:0] plane_n [3];
  logic signed [31:0] plane_d;
  crossing_t expected_crossings[$];

  function automatic logic signed [127:0] plane_distance(input logic signed [31:0] p [3]);
    logic signed [127:0] acc;
    acc = 128'(plane_d) <<< 16;
    for (int i = 0; i < 3; i++) acc += 128'(plane_n[i]) * 128'(p[i]);
    return acc;
  endfunction

  function automatic crossing_t predict_crossing(input logic [191:0] seg);
    logic signed [31:0] s [3];
    logic signed [31:0] e [3];
    logic signed [127:0] d1, d2;
    logic [127:0] num, den;
    logic [63:0] frac, mag, q;
    logic signed [63:0] delta;
    logic [31:0] pt [3];
    crossing_t r;
    for (int i = 0; i < 3; i++) begin
      s[i] = seg[32*i +: 32];
      e[i] = seg[32*(i+3) +: 32];
    end
    d1 = plane_distance(s);
    d2 = plane_distance(e);
    r = '0;
    if (d1[127] != d2[127]) begin
      num = d1[127] ? -d1 : d1;
      den = num + (d2[127] ? -d2 : d2);
      frac = 64'((num << 16) / den);
      for (int i = 0; i < 3; i++) begin
        delta = 64'(e[i]) - 64'(s[i]);
        mag = delta[63] ? -delta : delta;
        q = 64'((128'(mag) * 128'(frac)) >> 16);
        pt[i] = 32'(64'(s[i]) + (delta[63] ? -q : q));
      end
      r = {1'b1, pt[0], pt[1], pt[2]};
    end
    return r;
  endfunction

  assign pending = expected_crossings.size();

  always @(posedge clk) begin
    crossing_t exp_c;
    if (!rst_n) begin
      plane_n = '{0, 0, 0};
      plane_d = 0;
      expected_crossings.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (psi_reg_t'(cfg_index))
          REG_NORMAL_X:     plane_n[0] = cfg_data;
          REG_NORMAL_Y:     plane_n[1] = cfg_data;
          REG_NORMAL_Z:     plane_n[2] = cfg_data;
          REG_PLANE_OFFSET: plane_d = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_crossings.size() == 0) begin
          $error("unexpected result transaction hit=%0b data=%h", out_tuser, out_tdata);
          fail_count++;
        end else begin
          exp_c = expected_crossings.pop_front();
          if (out_tuser !== exp_c.hit) begin
            $error("hit: expected %0b actual %0b", exp_c.hit, out_tuser);
            fail_count++;
          end
          if (out_tdata[31:0] !== exp_c.px) begin
            $error("point_x: expected %h actual %h", exp_c.px, out_tdata[31:0]);
            fail_count++;
          end
          if (out_tdata[63:32] !== exp_c.py) begin
            $error("point_y: expected %h actual %h", exp_c.py, out_tdata[63:32]);
            fail_count++;
          end
          if (out_tdata[95:64] !== exp_c.pz) begin
            $error("point_z: expected %h actual %h", exp_c.pz, out_tdata[95:64]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) expected_crossings.push_back(predict_crossing(in_tdata));
    end
  end
endmodule

### tb/plane_segment_intersection_test.sv
// testbench top: stimulus, configuration phases and verdict
`timescale 1ns / 1ps
module plane_segment_intersection_test;
  import psi_pkg::*;

  localparam int LATENCY = 21;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [191:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [95:0] out_tdata;
  logic out_tuser;
  int fail_count, pending;
  bit quiet = 0;
  bit hold_long = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  plane_segment_intersection DUT (.*);
  plane_segment_intersection_checker chk (.*);

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // leaves cfg_valid high so back-to-back writes need no second assignment
  task automatic write_plane_reg(input psi_reg_t idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_plane(input logic [31:0] nx, ny, nz, d);
    write_plane_reg(REG_NORMAL_X, nx);
    write_plane_reg(REG_NORMAL_Y, ny);
    write_plane_reg(REG_NORMAL_Z, nz);
    write_plane_reg(REG_PLANE_OFFSET, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // sender gap precedes the transaction so valid drops between items only during a gap
  task automatic send_segment(input logic [191:0] seg);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= seg;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_input;
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 400)) - 200) <<< 16;
      2: return 32'($signed($urandom_range(0, 65535)) - 32768) <<< $urandom_range(0, 15);
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  function automatic logic [191:0] rand_segment;
    logic [191:0] seg;
    int mode;
    mode = $urandom_range(0, 9) < 6 ? 1 + ($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0 ? 3 : 0);
    for (int i = 0; i < 6; i++) seg[32*i +: 32] = rand_coord(mode);
    return seg;
  endfunction

  function automatic logic [191:0] pack_seg(input logic [31:0] sx, sy, sz, ex, ey, ez);
    return {ez, ey, ex, sz, sy, sx};
  endfunction

  // receiver: random stalls, one long hold-off on request, none when quiet
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        out_tready <= 0;
        repeat (300) @(posedge clk);
        hold_long = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1;
        @(posedge clk);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // zero normal at reset: never a hit
    send_segment(pack_seg(32'h80000000, 0, 0, 32'h7fffffff, 0, 0));
    idle_input();
    drain();

    // plane x = 0
    set_plane(32'h00010000, 0, 0, 0);
    send_segment(pack_seg(32'hffff0000, 5 << 16, 7, 1 << 16, 9 << 16, 3));
    send_segment(pack_seg(0, 1, 2, 32'hfffe0000, 3, 4));           // start on plane, end behind
    send_segment(pack_seg(32'hfffe0000, 3, 4, 0, 1, 2));           // end on plane
    send_segment(pack_seg(32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_segment(pack_seg(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h80000000, 32'h80000000, 32'h80000000));
    send_segment(pack_seg(1 << 16, 0, 0, 2 << 16, 0, 0));          // same side
    send_segment(pack_seg(32'hffffffff, 0, 0, 1, 0, 0));
    idle_input();
    drain();

    // extremes of all registers
    set_plane(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    for (int i = 0; i < 10; i++) send_segment(rand_segment());
    idle_input();
    drain();
    set_plane(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    for (int i = 0; i < 8; i++) send_segment(rand_segment());
    idle_input();
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 7) quiet = 1;
      case (phase % 3)
        0: set_plane(rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1));
        1: set_plane(rand_coord(2), rand_coord(2), rand_coord(2), rand_coord(2));
        default: set_plane($urandom(), $urandom(), $urandom(), $urandom());
      endcase
      if (phase == 2) hold_long = 1;
      for (int i = 0; i < 200; i++) send_segment(rand_segment());
      idle_input();
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

### plane_segment_intersection.f
hw/rtl/psi_pkg.sv
hw/rtl/psi_div.sv
hw/rtl/plane_segment_intersection.sv
tb/plane_segment_intersection_checker.sv
tb/plane_segment_intersection_test.sv
